// ===== rtl/gps_rational_dms_to_degrees_defines.svh =====
// assertion macros for the dms to degrees converter checker
// expects signals named clk and arst_n in the scope of use
`ifndef GPS_RATIONAL_DMS_TO_DEGREES_DEFINES_SVH
`define GPS_RATIONAL_DMS_TO_DEGREES_DEFINES_SVH

// same-cycle implication
`define GDD_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define GDD_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/gdd_pkg.sv =====
// shared constants, types and helpers for the dms to degrees converter
// no dependencies
`timescale 1ns / 1ps

package gdd_pkg;

	localparam int FRAC_BITS_DEF = 32;
	localparam int DEG_SCALE     = 1;
	localparam int MIN_SCALE     = 60;
	localparam int SEC_SCALE     = 3600;

	localparam logic [7:0] REF_SOUTH = 8'h53;
	localparam logic [7:0] REF_WEST  = 8'h57;

	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	typedef logic [63:0] rational_t;

	// reverse byte order of one 32-bit word
	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// ===== rtl/gdd_if.sv =====
// handshake channels of the dms to degrees converter
// depends on gdd_pkg
`timescale 1ns / 1ps

interface gdd_dms_if import gdd_pkg::*;;
	logic      valid;
	logic      ready;
	rational_t degrees_raw;
	rational_t minutes_raw;
	rational_t seconds_raw;
	logic [7:0] ref_char;
	logic      is_longitude;

	modport source (
		output valid, degrees_raw, minutes_raw, seconds_raw, ref_char, is_longitude,
		input  ready
	);
	modport sink (
		input  valid, degrees_raw, minutes_raw, seconds_raw, ref_char, is_longitude,
		output ready
	);
endinterface

interface gdd_deg_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] coordinate_fixed;
	logic               saturated;

	modport source (output valid, coordinate_fixed, saturated, input ready);
	modport sink (input valid, coordinate_fixed, saturated, output ready);
endinterface

// ===== rtl/gdd_lane.sv =====
// one lane: unpack a rational, scale the denominator, restoring divider pipeline
// depends on gdd_pkg
`timescale 1ns / 1ps

module gdd_lane import gdd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SCALE     = DEG_SCALE
) (
	input  logic                    clk,
	input  logic                    en,
	input  rational_t               raw,
	input  logic                    little_endian,
	output logic [32+FRAC_BITS-1:0] quotient
);

	localparam int DVD_W  = 32 + FRAC_BITS;
	localparam int DIV_W  = 32 + $clog2(SCALE);
	localparam int STAGES = DVD_W;

	logic [31:0]      num;
	logic [31:0]      den;
	logic [DVD_W-1:0] dividend;
	logic [DIV_W-1:0] divisor;

	// floor(floor(a/b)/c) == floor(a/(b*c)), so the scale folds into the divisor
	always_comb begin
		if (little_endian) begin
			num = raw[31:0];
			den = raw[63:32];
		end else begin
			num = swap32(raw[31:0]);
			den = swap32(raw[63:32]);
		end
		if (den == 32'd0) begin
			dividend = '0;
			divisor  = DIV_W'(1);
		end else begin
			dividend = {num, {FRAC_BITS{1'b0}}};
			divisor  = DIV_W'(DIV_W'(den) * DIV_W'(SCALE));
		end
	end

	logic [DIV_W-1:0] rem_s [STAGES];
	logic [DIV_W-1:0] dsr_s [STAGES];
	logic [DVD_W-1:0] acc_s [STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			dsr_s[0] <= divisor;
			acc_s[0] <= dividend;
		end
	end

	// one quotient bit per stage; acc shifts dividend out and quotient in
	for (genvar k = 1; k <= STAGES; k++) begin : g_stage
		logic [DIV_W:0] trial;
		logic [DIV_W:0] diff;
		logic           fits;

		assign trial = {rem_s[k-1], acc_s[k-1][DVD_W-1]};
		assign diff  = trial - {1'b0, dsr_s[k-1]};
		assign fits  = ~diff[DIV_W];

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k] <= {acc_s[k-1][DVD_W-2:0], fits};
			end
		end

		if (k < STAGES) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
					dsr_s[k] <= dsr_s[k-1];
				end
			end
		end
	end

	assign quotient = acc_s[STAGES];

endmodule

// ===== rtl/gps_rational_dms_to_degrees.sv =====
// gps dms rationals to signed fixed-point decimal degrees, top level
// depends on gdd_pkg, gdd_if, gdd_lane
//
// usage
//   dms channel (sink): one coordinate per beat, three raw 8-byte rationals
//   (degrees, minutes, seconds), the reference character and the axis flag
//   degrees channel (source): one beat per coordinate, coordinate_fixed with
//   FRAC_BITS fraction bits and a saturated flag, in input order
//   cfg_we / cfg_wdata: byte order register, 1 little endian, 0 big endian
// pipeline: one unpack stage, one stage per quotient bit in each of three
//   divider lanes, one stage for the lane sum, then the output register
// throughput: one coordinate per cycle while the skid register is empty, set
//   by the one-bit-per-stage divider pipelines, which all advance together
// reset: all beats in flight are dropped, byte order returns to little endian
// stall: a result waiting at the output does not block intake; a second one
//   lands in a skid register, and only while that is full is dms.ready low
//   and the pipeline held
`timescale 1ns / 1ps

module gps_rational_dms_to_degrees import gdd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gdd_dms_if.sink   dms,
	gdd_deg_if.source degrees,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	localparam int DVD_W = 32 + FRAC_BITS;
	localparam int SUM_W = DVD_W + 2;

	// byte order register
	logic le_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q <= 1'b1;
		end else if (cfg_we) begin
			le_q <= cfg_wdata;
		end
	end

	// whole pipeline moves together, held only while the skid is occupied
	logic skid_full_q;
	logic pipe_en;

	assign pipe_en   = ~skid_full_q;
	assign dms.ready = pipe_en;

	// sign decision for this beat
	logic neg_in;
	assign neg_in = dms.is_longitude ? (dms.ref_char == REF_WEST)
	                                 : (dms.ref_char == REF_SOUTH);

	// valid and sign travel beside the lanes: index 0 is the unpack stage
	logic [DVD_W:0] vld_q;
	logic [DVD_W:0] neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[DVD_W-1:0], dms.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			neg_q <= {neg_q[DVD_W-1:0], neg_in};
		end
	end

	// three divider lanes
	logic [DVD_W-1:0] deg_term;
	logic [DVD_W-1:0] min_term;
	logic [DVD_W-1:0] sec_term;

	gdd_lane #(.FRAC_BITS(FRAC_BITS), .SCALE(DEG_SCALE)) u_lane_deg (
		.clk          (clk),
		.en           (pipe_en),
		.raw          (dms.degrees_raw),
		.little_endian(le_q),
		.quotient     (deg_term)
	);

	gdd_lane #(.FRAC_BITS(FRAC_BITS), .SCALE(MIN_SCALE)) u_lane_min (
		.clk          (clk),
		.en           (pipe_en),
		.raw          (dms.minutes_raw),
		.little_endian(le_q),
		.quotient     (min_term)
	);

	gdd_lane #(.FRAC_BITS(FRAC_BITS), .SCALE(SEC_SCALE)) u_lane_sec (
		.clk          (clk),
		.en           (pipe_en),
		.raw          (dms.seconds_raw),
		.little_endian(le_q),
		.quotient     (sec_term)
	);

	// merge: sum of the three terms, two guard bits so nothing wraps
	logic             sum_vld_q;
	logic [SUM_W-1:0] sum_s;
	logic             sum_neg_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vld_q <= 1'b0;
		end else if (pipe_en) begin
			sum_vld_q <= vld_q[DVD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sum_s     <= SUM_W'(deg_term) + SUM_W'(min_term) + SUM_W'(sec_term);
			sum_neg_s <= neg_q[DVD_W];
		end
	end

	// sign and clamp; a magnitude of exactly 2^63 is fine when negative
	logic [65:0] mag;
	logic [63:0] res;
	logic        sat;

	always_comb begin
		mag = 66'(sum_s);
		if (sum_neg_s) begin
			if (mag > {2'b00, NEG_LIMIT}) begin
				res = NEG_LIMIT;
				sat = 1'b1;
			end else begin
				res = 64'd0 - mag[63:0];
				sat = 1'b0;
			end
		end else begin
			if (mag > {2'b00, POS_LIMIT}) begin
				res = POS_LIMIT;
				sat = 1'b1;
			end else begin
				res = mag[63:0];
				sat = 1'b0;
			end
		end
	end

	// output register plus one skid entry
	logic        out_vld_q;
	logic [63:0] out_coord_q;
	logic        out_sat_q;
	logic [63:0] skid_coord_q;
	logic        skid_sat_q;

	logic arrive;
	logic take;
	logic load_out;
	logic load_skid;

	assign arrive    = pipe_en & sum_vld_q;
	assign take      = out_vld_q & degrees.ready;
	assign load_out  = skid_full_q ? take : (arrive & (~out_vld_q | take));
	assign load_skid = ~skid_full_q & arrive & out_vld_q & ~take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (take) begin
				out_vld_q <= 1'b0;
			end
			if (load_skid) begin
				skid_full_q <= 1'b1;
			end else if (take) begin
				skid_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_coord_q <= skid_full_q ? skid_coord_q : res;
			out_sat_q   <= skid_full_q ? skid_sat_q : sat;
		end
		if (load_skid) begin
			skid_coord_q <= res;
			skid_sat_q   <= sat;
		end
	end

	assign degrees.valid            = out_vld_q;
	assign degrees.coordinate_fixed = out_coord_q;
	assign degrees.saturated        = out_sat_q;

endmodule

// ===== rtl/gdd_checker.sv =====
// port-level checks for the dms to degrees converter, bound to the top level
// depends on gdd_pkg and gps_rational_dms_to_degrees_defines.svh
`timescale 1ns / 1ps
`include "gps_rational_dms_to_degrees_defines.svh"

module gdd_port_checker import gdd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] coordinate,
	input logic        saturated
);

	logic out_held;
	logic at_limit;

	assign out_held = out_valid && !out_ready;
	assign at_limit = (coordinate == POS_LIMIT) || (coordinate == NEG_LIMIT);

	// a result held back keeps its value
	`GDD_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(coordinate), "held beat changed")

	// intake only closes while a result is waiting
	`GDD_ASSERT_IMP(a_ready_needs_stall, !in_ready, out_valid, "intake closed with empty output")

	// intake closes only after a refused result
	`GDD_ASSERT_IMP(a_ready_fall, $fell(in_ready), $past(out_held), "intake closed without a stall")

	// a clamped result sits at one of the two limits
	`GDD_ASSERT_IMP(a_sat_limit, out_valid && saturated, at_limit, "saturated result off limit")

endmodule

bind gps_rational_dms_to_degrees gdd_port_checker u_gdd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (dms.ready),
	.out_valid (degrees.valid),
	.out_ready (degrees.ready),
	.coordinate(degrees.coordinate_fixed),
	.saturated (degrees.saturated)
);
